/* rtl/icods_pkg.sv */
package icods_pkg;

	localparam int unsigned MaxEntries = 256;
	localparam int unsigned CountW     = 9;
	localparam int unsigned HdrBytes   = 6;
	localparam int unsigned EntryBytes = 16;

	// header position meaning "inside the directory"
	localparam logic [2:0] HDR_DIR = 3'd6;

	// directory entry field byte offsets
	localparam logic [3:0] FLD_WIDTH  = 4'd0;
	localparam logic [3:0] FLD_HEIGHT = 4'd1;
	localparam logic [3:0] FLD_BITS0  = 4'd6;
	localparam logic [3:0] FLD_BITS1  = 4'd7;
	localparam logic [3:0] FLD_LAST   = 4'd15;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT      = 3'd1,
		ST_BAD_RSVD   = 3'd2,
		ST_BAD_TYPE   = 3'd3,
		ST_BAD_COUNT  = 3'd4,
		ST_DIR_BEYOND = 3'd5,
		ST_NO_ENTRY   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ICON   = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	// one directory entry as kept for the winner
	typedef struct packed {
		logic [31:0] size;
		logic [31:0] offset;
		logic [15:0] bits;
		logic [8:0]  height;
		logic [8:0]  width;
		logic [7:0]  index;
	} entry_rec_t;

	// result word, first field in the high bits
	typedef struct packed {
		entry_rec_t   best;
		logic [8:0]   entry_count;
		logic [1:0]   image_type;
		logic [2:0]   status;
	} result_t;

	typedef struct packed {
		logic clear;   // restart of a file
		logic judge;   // usable entry finished this cycle
	} best_ctl_t;

endpackage

/* rtl/icods_best.sv */
// Keeps the best usable entry: largest area, then higher bit count,
// earliest on a full tie. The next-state values are also exported so
// that a result taken on the judging cycle sees the final winner.
module icods_best (
	input  logic                   clk,
	input  logic                   arst_n,
	input  icods_pkg::best_ctl_t   ctl,
	input  icods_pkg::entry_rec_t  cand,
	input  logic [16:0]            cand_area,
	output logic                   have_nxt,
	output icods_pkg::entry_rec_t  rec_nxt
);

	logic                  have_q;
	logic [16:0]           area_q;
	icods_pkg::entry_rec_t rec_q;
	logic [16:0]           area_nxt;
	logic                  take;

	assign take = ctl.judge && (!have_q || ctl.clear || cand_area > area_q ||
		(cand_area == area_q && cand.bits > rec_q.bits));

	always_comb begin
		have_nxt = ctl.clear ? 1'b0 : have_q;
		area_nxt = area_q;
		rec_nxt  = rec_q;
		if (take) begin
			have_nxt = 1'b1;
			area_nxt = cand_area;
			rec_nxt  = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else begin
			have_q <= have_nxt;
		end
	end

	always_ff @(posedge clk) begin
		area_q <= area_nxt;
		rec_q  <= rec_nxt;
	end

endmodule

/* rtl/ico_directory_select.sv */
// ICO/CUR directory scanner.
// Input stream: one file byte per request. s_axis_tdata is the byte,
// s_axis_tuser marks byte 0 of a new file and restarts the parse.
// Bytes that arrive after a result, or after reset, without the marker
// are dropped. file_length must be written through cfg_wr_en/cfg_wr_data
// only while no file is in flight; the block itself does not enforce this.
// The 6-byte header is checked (length, reserved, type, count, directory
// fit), then every 16-byte entry is read and the largest usable image
// is kept. One result request leaves on the m_axis side at the first
// error or after the last directory byte; best fields are zero on error.
// Throughput: one byte per cycle while the receiver takes results, set by
// the single input register and single result register with the parse
// logic in between. The deciding byte passes the input register, then the
// result register. Entry area is a 9x9 multiply registered at the height
// byte. When the receiver stalls, the result is held in the output register;
// the input register takes at most one more byte, then waits for the result.
// Reset (arst_n low) idles the parser, empties both registers and
// clears file_length to zero.
module ico_directory_select (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [31:0]   cfg_wr_data,     // file_length
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,    // data_byte
	input  logic          s_axis_tuser,    // first_byte
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// status[2:0], image_type[4:3], entry_count[13:5], best_index[21:14],
	// best_width[30:22], best_height[39:31], best_bits[55:40],
	// best_offset[87:56], best_size[119:88]
	output logic [119:0]  m_axis_tdata
);

	logic [31:0] file_length_q;

	// input register
	logic       in_valid_s1;
	logic [7:0] in_data_s1;
	logic       in_first_s1;
	logic       advance;

	// parse state
	logic        done_q;
	logic [2:0]  hpos_q;
	logic [15:0] hshift_q;
	logic [1:0]  kind_q;
	logic [8:0]  count_q;
	logic [8:0]  idx_q;
	logic [3:0]  fld_q;
	logic [8:0]  cur_w_q;
	logic [8:0]  cur_h_q;
	logic [16:0] area_q;
	logic [15:0] bits_q;
	logic [31:0] size_q;
	logic [31:0] offset_q;

	// result register
	logic                 m_valid_q;
	icods_pkg::result_t   m_data_q;

	// next-state values
	logic        step;
	logic        done_nxt;
	logic [2:0]  hpos_nxt;
	logic [15:0] hshift_nxt;
	logic [1:0]  kind_nxt;
	logic [8:0]  count_nxt;
	logic [8:0]  idx_nxt;
	logic [3:0]  fld_nxt;
	logic [8:0]  cur_w_nxt;
	logic [8:0]  cur_h_nxt;
	logic        area_ld;
	logic [15:0] bits_nxt;
	logic [31:0] size_nxt;
	logic [31:0] offset_nxt;
	logic        res_fire;
	icods_pkg::status_t res_status;
	logic [8:0]  byte_dim;
	logic [17:0] area_prod;
	logic [32:0] end_sum;
	logic        usable;
	logic [12:0] dir_end;

	icods_pkg::best_ctl_t  best_ctl;
	icods_pkg::entry_rec_t cand;
	icods_pkg::entry_rec_t best_rec;
	logic                  best_have;
	icods_pkg::result_t    res;

	assign advance       = in_valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign step          = advance && (in_first_s1 || !done_q);

	// zero byte stands for 256
	assign byte_dim  = (in_data_s1 == 8'd0) ? 9'd256 : {1'b0, in_data_s1};
	assign area_prod = cur_w_q * byte_dim;
	assign dir_end   = 13'(icods_pkg::HdrBytes) +
		13'({hshift_nxt[8:0], 4'b0000});

	// complete entry, offset takes its top byte this cycle
	assign cand.size   = size_q;
	assign cand.offset = {in_data_s1, offset_q[31:8]};
	assign cand.bits   = bits_q;
	assign cand.height = cur_h_q;
	assign cand.width  = cur_w_q;
	assign cand.index  = idx_q[7:0];

	assign end_sum = {1'b0, cand.offset} + {1'b0, size_q};
	assign usable  = (size_q != 32'd0) && (end_sum <= {1'b0, file_length_q});

	always_comb begin
		done_nxt   = done_q;
		hpos_nxt   = hpos_q;
		hshift_nxt = hshift_q;
		kind_nxt   = kind_q;
		count_nxt  = count_q;
		idx_nxt    = idx_q;
		fld_nxt    = fld_q;
		cur_w_nxt  = cur_w_q;
		cur_h_nxt  = cur_h_q;
		area_ld    = 1'b0;
		bits_nxt   = bits_q;
		size_nxt   = size_q;
		offset_nxt = offset_q;
		res_fire   = 1'b0;
		res_status = icods_pkg::ST_OK;
		best_ctl   = '0;

		if (step) begin
			if (in_first_s1) begin
				done_nxt   = 1'b0;
				hpos_nxt   = 3'd0;
				hshift_nxt = 16'd0;
				kind_nxt   = icods_pkg::KIND_NONE;
				count_nxt  = 9'd0;
				idx_nxt    = 9'd0;
				fld_nxt    = 4'd0;
				best_ctl.clear = 1'b1;
			end

			if (hpos_nxt != icods_pkg::HDR_DIR) begin
				hshift_nxt = {in_data_s1, hshift_nxt[15:8]};
				priority if (hpos_nxt == 3'd0 &&
						file_length_q < 32'(icods_pkg::HdrBytes)) begin
					res_fire   = 1'b1;
					res_status = icods_pkg::ST_SHORT;
				end else if (hpos_nxt == 3'd1 && hshift_nxt != 16'd0) begin
					res_fire   = 1'b1;
					res_status = icods_pkg::ST_BAD_RSVD;
				end else if (hpos_nxt == 3'd3) begin
					if (hshift_nxt != 16'(icods_pkg::KIND_ICON) &&
							hshift_nxt != 16'(icods_pkg::KIND_CURSOR)) begin
						res_fire   = 1'b1;
						res_status = icods_pkg::ST_BAD_TYPE;
					end else begin
						kind_nxt = hshift_nxt[1:0];
					end
				end else if (hpos_nxt == 3'd5) begin
					if (hshift_nxt == 16'd0 ||
							hshift_nxt > 16'(icods_pkg::MaxEntries)) begin
						res_fire   = 1'b1;
						res_status = icods_pkg::ST_BAD_COUNT;
					end else begin
						count_nxt = hshift_nxt[8:0];
						if ({19'd0, dir_end} > file_length_q) begin
							res_fire   = 1'b1;
							res_status = icods_pkg::ST_DIR_BEYOND;
						end
					end
				end else begin
					res_fire = 1'b0;
				end
				hpos_nxt = hpos_nxt + 3'd1;
			end else begin
				unique case (fld_nxt)
					icods_pkg::FLD_WIDTH: cur_w_nxt = byte_dim;
					icods_pkg::FLD_HEIGHT: begin
						cur_h_nxt = byte_dim;
						area_ld   = 1'b1;
					end
					icods_pkg::FLD_BITS0, icods_pkg::FLD_BITS1:
						bits_nxt = {in_data_s1, bits_q[15:8]};
					4'd8, 4'd9, 4'd10, 4'd11:
						size_nxt = {in_data_s1, size_q[31:8]};
					4'd12, 4'd13, 4'd14, 4'd15:
						offset_nxt = {in_data_s1, offset_q[31:8]};
					default: ;
				endcase
				if (fld_nxt == icods_pkg::FLD_LAST) begin
					best_ctl.judge = usable;
					idx_nxt        = idx_nxt + 9'd1;
					if (idx_nxt >= count_nxt) begin
						res_fire = 1'b1;
					end
				end
				fld_nxt = fld_nxt + 4'd1;
			end

			if (res_fire) begin
				done_nxt = 1'b1;
			end
		end
	end

	icods_best u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (best_ctl),
		.cand      (cand),
		.cand_area (area_q),
		.have_nxt  (best_have),
		.rec_nxt   (best_rec)
	);

	always_comb begin
		res.status      = res_status;
		res.image_type  = kind_nxt;
		res.entry_count = count_nxt;
		res.best        = '0;
		if (res_status == icods_pkg::ST_OK) begin
			if (best_have) begin
				res.best = best_rec;
			end else begin
				res.status = icods_pkg::ST_NO_ENTRY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= 32'd0;
			in_valid_s1   <= 1'b0;
			m_valid_q     <= 1'b0;
			done_q        <= 1'b1;
			hpos_q        <= 3'd0;
			hshift_q      <= 16'd0;
			kind_q        <= icods_pkg::KIND_NONE;
			count_q       <= 9'd0;
			idx_q         <= 9'd0;
			fld_q         <= 4'd0;
		end else begin
			if (cfg_wr_en) begin
				file_length_q <= cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_valid_s1 <= 1'b1;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (res_fire) begin
				m_valid_q <= 1'b1;
			end
			done_q   <= done_nxt;
			hpos_q   <= hpos_nxt;
			hshift_q <= hshift_nxt;
			kind_q   <= kind_nxt;
			count_q  <= count_nxt;
			idx_q    <= idx_nxt;
			fld_q    <= fld_nxt;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_s1  <= s_axis_tdata;
			in_first_s1 <= s_axis_tuser;
		end
		if (res_fire) begin
			m_data_q <= res;
		end
		if (area_ld) begin
			area_q <= area_prod[16:0];
		end
		cur_w_q  <= cur_w_nxt;
		cur_h_q  <= cur_h_nxt;
		bits_q   <= bits_nxt;
		size_q   <= size_nxt;
		offset_q <= offset_nxt;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
